// ----- hdl/corner_state_unrank_assert.svh -----
// corner_state_unrank_assert.svh: assertion macros for the corner state decoder
// no dependencies; included by the top level
`ifndef CORNER_STATE_UNRANK_ASSERT_SVH
`define CORNER_STATE_UNRANK_ASSERT_SVH

// cons must hold in every cycle where ante holds
`define CSU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("corner_state_unrank: implication check failed");

// cond must never hold out of reset
`define CSU_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("corner_state_unrank: forbidden condition seen");

`endif

// ----- hdl/csu_pkg.sv -----
// csu_pkg: widths, constants and cell payload types for the corner state decoder
// no dependencies; used by the interfaces, the cells and the top level
`timescale 1ns / 1ps
`default_nettype none

package csu_pkg;

    localparam int SLOTS       = 8;
    localparam int TERN_DIGITS = SLOTS - 1;
    localparam int INDEX_W     = 27;
    localparam int RANK_W      = 16;
    localparam int ITEM_W      = 3;
    localparam int TWIST_W     = 2;
    localparam int PERM_W      = SLOTS * ITEM_W;
    localparam int ORIENT_W    = SLOTS * TWIST_W;
    localparam int TERN_W      = TERN_DIGITS * TWIST_W;

    // 8! * 3^7
    localparam logic [INDEX_W-1:0] INDEX_LIMIT = 27'd88179840;

    // floor(x / 3) = (x * RECIP3) >> RECIP3_SHIFT, exact for any 27-bit x
    localparam int                 RECIP3_SHIFT = 28;
    localparam logic [INDEX_W-1:0] RECIP3       = 27'd89478486;
    localparam int                 PROD_W       = 2 * INDEX_W;

    localparam logic [2:0] TWIST_MOD = 3'd3;

    typedef logic [SLOTS-1:0][ITEM_W-1:0] t_avail;

    typedef struct packed {
        logic [INDEX_W-1:0] x;
        logic [TERN_W-1:0]  orient;
        logic [TWIST_W-1:0] sum;
        logic               invalid;
    } t_tern_data;

    typedef struct packed {
        logic [RANK_W-1:0]   rank;
        t_avail              avail;
        logic [PERM_W-1:0]   perm;
        logic [ORIENT_W-1:0] orient;
        logic                invalid;
    } t_lehmer_data;

    function automatic int fact(input int n);
        int f;
        f = 1;
        for (int k = 2; k <= n; k++) begin
            f = f * k;
        end
        return f;
    endfunction

    function automatic t_avail init_avail();
        t_avail a;
        for (int j = 0; j < SLOTS; j++) begin
            a[j] = ITEM_W'(j);
        end
        return a;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/csu_in_if.sv -----
// csu_in_if: input channel carrying one state index per transfer
// depends on csu_pkg
`timescale 1ns / 1ps
`default_nettype none

interface csu_in_if;
    logic                         valid;
    logic                         ready;
    logic [csu_pkg::INDEX_W-1:0]  state_index;

    modport source (output valid, output state_index, input ready);
    modport sink   (input valid, input state_index, output ready);
endinterface

`default_nettype wire

// ----- hdl/csu_out_if.sv -----
// csu_out_if: output channel carrying one decoded corner state per transfer
// depends on csu_pkg
`timescale 1ns / 1ps
`default_nettype none

interface csu_out_if;
    logic                          valid;
    logic                          ready;
    logic [csu_pkg::PERM_W-1:0]    perm_packed;
    logic [csu_pkg::ORIENT_W-1:0]  orient_packed;
    logic                          index_invalid;

    modport source (output valid, output perm_packed, output orient_packed,
                    output index_invalid, input ready);
    modport sink   (input valid, input perm_packed, input orient_packed,
                    input index_invalid, output ready);
endinterface

`default_nettype wire

// ----- hdl/corner_state_unrank.sv -----
// corner_state_unrank: an input transfer passes 7 base-3 cells, then 8 factorial-base cells,
// to the result; throughput one index per cycle through the cell row unless the output stalls.
// each cell holds one item and moves when the next cell is empty or moving, so bubbles
// close up while the output is stalled. reset (synchronous, active low) empties every
// cell; there is no other state. out-of-range indexes give zero results with the flag set.
// depends on csu_pkg, csu_in_if, csu_out_if, csu_tern_cell, csu_lehmer_cell
`timescale 1ns / 1ps
`default_nettype none

`include "corner_state_unrank_assert.svh"

module corner_state_unrank (
    input  wire         i_clk,
    input  wire         i_rst_n,
    csu_in_if.sink      i_in,
    csu_out_if.source   o_out
);
    import csu_pkg::*;

    t_tern_data    w_td  [0:TERN_DIGITS];
    logic          w_tv  [0:TERN_DIGITS];
    logic          w_ten [0:TERN_DIGITS];
    t_lehmer_data  w_ld  [0:SLOTS];
    logic          w_lv  [0:SLOTS];
    logic          w_len [0:SLOTS];

    logic                w_invalid;
    logic [TWIST_W-1:0]  w_twist_last;
    logic [SLOTS-1:0]    w_perm_mask;
    logic                w_twist_bad;

    // out-of-range indexes travel as zero with the flag set
    assign w_invalid        = i_in.state_index >= INDEX_LIMIT;
    assign w_td[0].x        = w_invalid ? '0 : i_in.state_index;
    assign w_td[0].orient   = '0;
    assign w_td[0].sum      = '0;
    assign w_td[0].invalid  = w_invalid;
    assign w_tv[0]          = i_in.valid;
    assign i_in.ready       = w_ten[0];

    genvar g;
    generate
        for (g = 0; g < TERN_DIGITS; g++) begin : g_tern
            csu_tern_cell #(.SLOT(g)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_tv[g]),
                .i_data  (w_td[g]),
                .i_adv   (w_ten[g+1]),
                .o_en    (w_ten[g]),
                .o_valid (w_tv[g+1]),
                .o_data  (w_td[g+1])
            );
        end
    endgenerate

    // eighth twist brings the twist sum to 0 mod 3
    assign w_twist_last = (w_td[TERN_DIGITS].sum == '0) ? '0
                        : TWIST_W'(TWIST_MOD - 3'(w_td[TERN_DIGITS].sum));

    assign w_ten[TERN_DIGITS] = w_len[0];
    assign w_lv[0]            = w_tv[TERN_DIGITS];
    assign w_ld[0].rank       = RANK_W'(w_td[TERN_DIGITS].x);
    assign w_ld[0].avail      = init_avail();
    assign w_ld[0].perm       = '0;
    assign w_ld[0].orient     = {w_twist_last, w_td[TERN_DIGITS].orient};
    assign w_ld[0].invalid    = w_td[TERN_DIGITS].invalid;

    generate
        for (g = 0; g < SLOTS; g++) begin : g_lehmer
            csu_lehmer_cell #(.SLOT(g)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_lv[g]),
                .i_data  (w_ld[g]),
                .i_adv   (w_len[g+1]),
                .o_en    (w_len[g]),
                .o_valid (w_lv[g+1]),
                .o_data  (w_ld[g+1])
            );
        end
    endgenerate

    assign w_len[SLOTS]        = o_out.ready;
    assign o_out.valid         = w_lv[SLOTS];
    assign o_out.index_invalid = w_ld[SLOTS].invalid;
    assign o_out.perm_packed   = w_ld[SLOTS].invalid ? '0 : w_ld[SLOTS].perm;
    assign o_out.orient_packed = w_ld[SLOTS].invalid ? '0 : w_ld[SLOTS].orient;

    // checking aids: items seen in the result and any twist out of range
    always_comb begin
        w_perm_mask = '0;
        w_twist_bad = 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
            w_perm_mask[o_out.perm_packed[ITEM_W*s +: ITEM_W]] = 1'b1;
            if (o_out.orient_packed[TWIST_W*s +: TWIST_W] == TWIST_W'(TWIST_MOD)) begin
                w_twist_bad = 1'b1;
            end
        end
    end

    `CSU_ASSERT_IMPLY(a_perm_is_permutation, i_clk, i_rst_n,
        o_out.valid && !o_out.index_invalid, w_perm_mask == '1)
    `CSU_ASSERT_NEVER(a_twist_in_range, i_clk, i_rst_n, o_out.valid && w_twist_bad)
    `CSU_ASSERT_IMPLY(a_ready_when_drained, i_clk, i_rst_n,
        !o_out.valid || o_out.ready, i_in.ready)

endmodule

`default_nettype wire

// ----- hdl/csu_tern_cell.sv -----
// csu_tern_cell: one base-3 digit cell, divides the running value by 3
// depends on csu_pkg
`timescale 1ns / 1ps
`default_nettype none

module csu_tern_cell #(
    parameter int SLOT = 0
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  csu_pkg::t_tern_data  i_data,
    input  wire                  i_adv,
    output logic                 o_en,
    output logic                 o_valid,
    output csu_pkg::t_tern_data  o_data
);
    import csu_pkg::*;

    logic                r_valid;
    t_tern_data          r_data;
    t_tern_data          n_data;
    logic [PROD_W-1:0]   w_prod;
    logic [INDEX_W-1:0]  w_q;
    logic [INDEX_W+1:0]  w_q3;
    logic [TWIST_W-1:0]  w_r;
    logic [2:0]          w_s;

    always_comb begin
        w_prod = PROD_W'(i_data.x) * PROD_W'(RECIP3);
        w_q    = INDEX_W'(w_prod >> RECIP3_SHIFT);
        w_q3   = (INDEX_W+2)'({w_q, 1'b0}) + (INDEX_W+2)'(w_q);
        w_r    = TWIST_W'((INDEX_W+2)'(i_data.x) - w_q3);
        w_s    = 3'(i_data.sum) + 3'(w_r);

        n_data         = i_data;
        n_data.x       = w_q;
        n_data.orient[TWIST_W*SLOT +: TWIST_W] = w_r;
        n_data.sum     = (w_s >= TWIST_MOD) ? TWIST_W'(w_s - TWIST_MOD) : TWIST_W'(w_s);
    end

    assign o_en = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- hdl/csu_lehmer_cell.sv -----
// csu_lehmer_cell: one factorial-base digit cell, picks and removes one item
// depends on csu_pkg
`timescale 1ns / 1ps
`default_nettype none

module csu_lehmer_cell #(
    parameter int SLOT = 0
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    input  csu_pkg::t_lehmer_data  i_data,
    input  wire                    i_adv,
    output logic                   o_en,
    output logic                   o_valid,
    output csu_pkg::t_lehmer_data  o_data
);
    import csu_pkg::*;

    localparam int WEIGHT = fact(SLOTS - 1 - SLOT);
    localparam logic [ITEM_W-1:0] LAST = ITEM_W'(SLOTS - 1 - SLOT);

    logic               r_valid;
    t_lehmer_data       r_data;
    t_lehmer_data       n_data;
    logic [ITEM_W-1:0]  w_d;
    logic [RANK_W:0]    w_sub;
    logic [ITEM_W-1:0]  w_pick;

    // digit = rank / WEIGHT, found by comparing against every multiple
    always_comb begin
        w_d   = '0;
        w_sub = '0;
        for (int k = 1; k < SLOTS; k++) begin
            if ((RANK_W+1)'(i_data.rank) >= (RANK_W+1)'(k * WEIGHT)) begin
                w_d   = ITEM_W'(k);
                w_sub = (RANK_W+1)'(k * WEIGHT);
            end
        end
        // clamp to the items still in the list
        if (w_d > LAST) begin
            w_d   = LAST;
            w_sub = (RANK_W+1)'(SLOTS - 1 - SLOT) * (RANK_W+1)'(WEIGHT);
        end
    end

    always_comb begin
        w_pick = i_data.avail[w_d];

        n_data      = i_data;
        n_data.rank = RANK_W'((RANK_W+1)'(i_data.rank) - w_sub);
        n_data.perm[ITEM_W*SLOT +: ITEM_W] = w_pick;
        for (int j = 0; j < SLOTS - 1; j++) begin
            n_data.avail[j] = (ITEM_W'(j) < w_d) ? i_data.avail[j] : i_data.avail[j+1];
        end
        n_data.avail[SLOTS-1] = i_data.avail[SLOTS-1];
    end

    assign o_en = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

// ----- dv/corner_state_unrank_checker.sv -----
// corner_state_unrank_checker: predicts the decoded corner state for every input transfer
// and compares each output transfer with it in order
// depends on csu_pkg, csu_in_if, csu_out_if
`timescale 1ns / 1ps

module corner_state_unrank_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    csu_in_if    i_in,
    csu_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);

    import csu_pkg::*;

    localparam int unsigned TWIST_COMBOS = 2187;
    localparam int unsigned SLOT_WEIGHT [SLOTS] = '{1, 1, 2, 6, 24, 120, 720, 5040};
    localparam int          PRINT_CAP    = 40;

    typedef struct packed {
        logic [PERM_W-1:0]   perm;
        logic [ORIENT_W-1:0] orient;
        logic                invalid;
    } t_corner_state;

    t_corner_state decoded_q [$];

    function automatic t_corner_state decode_corner_state(input logic [INDEX_W-1:0] idx);
        t_corner_state st;
        logic [ITEM_W-1:0] pool [SLOTS];
        int unsigned rest;
        int unsigned digit;
        int unsigned left;
        int unsigned twist;
        int unsigned twist_sum;
        st = '0;
        if (idx >= INDEX_LIMIT) begin
            st.invalid = 1'b1;
            return st;
        end
        for (int k = 0; k < SLOTS; k++) begin
            pool[k] = ITEM_W'(k);
        end
        // factorial-base digits pick from the items still unused
        rest = int'(idx) / TWIST_COMBOS;
        left = SLOTS;
        for (int slot = 0; slot < SLOTS; slot++) begin
            digit = rest / SLOT_WEIGHT[SLOTS - 1 - slot];
            rest  = rest % SLOT_WEIGHT[SLOTS - 1 - slot];
            if (digit >= left) begin
                digit = left - 1;
            end
            st.perm[ITEM_W*slot +: ITEM_W] = pool[digit];
            for (int j = int'(digit); j + 1 < int'(left); j++) begin
                pool[j] = pool[j + 1];
            end
            left--;
        end
        // base-3 twists, last one closes the sum to 0 mod 3
        rest      = int'(idx) % TWIST_COMBOS;
        twist_sum = 0;
        for (int slot = 0; slot < TERN_DIGITS; slot++) begin
            twist = rest % 3;
            rest  = rest / 3;
            twist_sum += twist;
            st.orient[TWIST_W*slot +: TWIST_W] = TWIST_W'(twist);
        end
        st.orient[TWIST_W*TERN_DIGITS +: TWIST_W] = TWIST_W'((3 - twist_sum % 3) % 3);
        return st;
    endfunction

    task automatic enqueue_state(input t_corner_state st);
        decoded_q = {decoded_q, st};
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_fail_count < PRINT_CAP) begin
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        end
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_corner_state want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready) begin
                enqueue_state(decode_corner_state(i_in.state_index));
            end
            if (i_out.valid && i_out.ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("result with nothing pending", 32'(i_out.perm_packed), 0);
                end else begin
                    want = decoded_q.pop_front();
                    if (i_out.perm_packed !== want.perm) begin
                        report_mismatch("perm_packed", 32'(i_out.perm_packed), 32'(want.perm));
                    end
                    if (i_out.orient_packed !== want.orient) begin
                        report_mismatch("orient_packed", 32'(i_out.orient_packed),
                                        32'(want.orient));
                    end
                    if (i_out.index_invalid !== want.invalid) begin
                        report_mismatch("index_invalid", 32'(i_out.index_invalid),
                                        32'(want.invalid));
                    end
                end
            end
            o_pending <= decoded_q.size();
        end
    end

endmodule

// ----- dv/corner_state_unrank_tb.sv -----
// corner_state_unrank_tb: drives directed and random state indexes with bursty transfers
// and a stalling receiver, and gives the verdict from the checker's failure count
// depends on csu_pkg, csu_in_if, csu_out_if, corner_state_unrank, corner_state_unrank_checker
`timescale 1ns / 1ps

module corner_state_unrank_tb;

    import csu_pkg::*;

    localparam int unsigned LAST_VALID   = 88179839;
    localparam int unsigned ALL_ONES     = 134217727;
    localparam int unsigned RANDOM_ITEMS = 1780;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned HOLD_AT_ITEM = 400;
    localparam int unsigned HOLD_ITEMS   = 160;

    localparam logic [INDEX_W-1:0] DIRECTED_INDEXES [18] = '{
        27'd0,          // identity, no twist
        27'd1,
        27'd2,
        27'd3,
        27'd728,        // six twists of 2 below the top digit
        27'd1093,
        27'd2186,       // all seven free twists at 2
        27'd2187,       // first perm rank above identity
        27'd1594323,
        27'd11022480,   // leading lehmer digit 1
        27'd44089920,
        27'd67108864,   // top bit alone
        27'd88177653,   // reversed order, no twist
        27'd88179839,   // last valid index
        27'd88179840,   // first out of range
        27'd88179841,
        27'd100000000,
        27'd134217727   // all ones
    };

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    logic clk = 1'b0;
    logic rst_n;
    logic hold_req;
    int   fail_count;
    int   pending;
    int unsigned cycles = 0;

    csu_in_if  in_ch ();
    csu_out_if out_ch ();

    corner_state_unrank dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    corner_state_unrank_checker decode_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic offer_index(input logic [INDEX_W-1:0] idx, input int unsigned gap);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.state_index <= idx;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // mostly valid indexes, some built from corner ranks, some around and past the limit
    function automatic logic [INDEX_W-1:0] pick_index();
        int unsigned sel;
        int unsigned perm_rank;
        int unsigned twist_rank;
        sel = $urandom_range(0, 99);
        if (sel < 78) begin
            return INDEX_W'($urandom_range(0, LAST_VALID));
        end
        if (sel < 88) begin
            perm_rank  = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 40319)
                                                     : 40319 - $urandom_range(0, 30);
            twist_rank = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2186)
                                                     : 2186 * $urandom_range(0, 1);
            return INDEX_W'(perm_rank * 2187 + twist_rank);
        end
        if (sel < 94) begin
            return INDEX_W'(LAST_VALID - 40 + $urandom_range(0, 80));
        end
        return INDEX_W'($urandom_range(LAST_VALID + 1, ALL_ONES));
    endfunction

    // receiver: segments of different stall patterns, plus one long hold-off
    initial begin
        t_rx_mode    mode;
        int unsigned seg_left;
        int unsigned hold_left;
        int unsigned phase;
        int unsigned period;
        bit          hold_used;
        mode      = RX_OPEN;
        seg_left  = 0;
        hold_left = 0;
        phase     = 0;
        period    = 3;
        hold_used = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    mode     = t_rx_mode'($urandom_range(0, 3));
                    seg_left = $urandom_range(20, 200);
                    period   = $urandom_range(2, 7);
                end
                seg_left--;
                phase++;
                case (mode)
                    RX_OPEN:     out_ch.ready <= 1'b1;
                    RX_COIN:     out_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   out_ch.ready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: out_ch.ready <= (phase % period != 0);
                    default:     out_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    initial begin
        int unsigned burst_left;
        int unsigned gap;
        in_ch.valid       <= 1'b0;
        in_ch.state_index <= '0;
        rst_n             <= 1'b0;
        hold_req          <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_INDEXES[k]) begin
            offer_index(DIRECTED_INDEXES[k], $urandom_range(0, 2));
        end

        burst_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            gap = 0;
            if (n == HOLD_AT_ITEM) begin
                hold_req <= 1'b1;
            end
            // keep offering back to back while the receiver holds off
            if (n < HOLD_AT_ITEM || n >= HOLD_AT_ITEM + HOLD_ITEMS) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 60);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end
            offer_index(pick_index(), gap);
        end
        in_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
